// ===== hw/rtl/rsef_pkg.sv =====
`default_nettype none

package rsef_pkg;

    // Field widths
    localparam int VALUE_BITS      = 16;
    localparam int TIME_BITS       = 32;
    localparam int MODE_BITS       = 2;
    localparam int USED_BITS       = 5;
    localparam int DEF_MAX_SENSORS = 16;

    // Product magnitude and signed working width of the extrapolated value
    localparam int PROD_W = VALUE_BITS + TIME_BITS;
    localparam int VAL_W  = PROD_W + 2;

    // Fusion mode codes; the unused code answers as maximum
    localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_AVG = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MAG,
        ST_MUL,
        ST_DIV_PROD,
        ST_SIGN,
        ST_ADD,
        ST_FOLD,
        ST_ACC,
        ST_CLOSE,
        ST_DIV_AVG,
        ST_EMIT
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/rsef_div.sv =====
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module rsef_div #(
    parameter int DIVIDEND_W = rsef_pkg::PROD_W,
    parameter int DIVISOR_W  = rsef_pkg::TIME_BITS
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [DIVIDEND_W-1:0]     i_dividend,
    input  wire  [DIVISOR_W-1:0]      i_divisor,
    output logic [DIVIDEND_W-1:0]     o_quotient,
    output rsef_pkg::t_div_stat       o_stat
);
    import rsef_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = trial >= {1'b0, r_dvs};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ===== hw/rtl/range_sensor_extrapolate_fuse.sv =====
`default_nettype none

// Range sensor extrapolation and fusion. Each request carries one sensor's two
// latest timed readings, the current time and the sensor's limits; the block
// extrapolates linearly to now (quotient truncated toward zero), holds the newer
// reading when both sample times are equal, clamps to the limits and folds the
// value into a running max, min, sum and count. A request with last_sensor set
// closes the round and produces one result (max, min or average by fusion_mode).
// Requests are taken one at a time and the input stalls while one is worked on.
// Each sensor passes through these steps in order: accept, difference, take
// magnitudes, start the divide, run the shared 48-bit restoring divider (one
// quotient bit per cycle), then sign, add, clamp, fold and close. Equal sample
// times skip the multiply and divide. A closing sensor then loads the output
// register; in average mode the same divider first forms the round average.
// The load waits while a previous result is still stalled. Sensors beyond
// MAX_SENSORS in one round are not folded in.
// fusion_mode may be written only while the block is idle.
module range_sensor_extrapolate_fuse #(
    parameter int MAX_SENSORS = rsef_pkg::DEF_MAX_SENSORS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [rsef_pkg::MODE_BITS-1:0]      i_cfg_data,
    // sensor requests
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [rsef_pkg::VALUE_BITS-1:0]     i_older_value,
    input  wire  [rsef_pkg::VALUE_BITS-1:0]     i_newer_value,
    input  wire  [rsef_pkg::TIME_BITS-1:0]      i_older_time,
    input  wire  [rsef_pkg::TIME_BITS-1:0]      i_newer_time,
    input  wire  [rsef_pkg::TIME_BITS-1:0]      i_now_time,
    input  wire  [rsef_pkg::VALUE_BITS-1:0]     i_range_min,
    input  wire  [rsef_pkg::VALUE_BITS-1:0]     i_range_max,
    input  wire                                 i_last_sensor,
    // fused results
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [rsef_pkg::VALUE_BITS-1:0]     o_fused_value,
    output logic [rsef_pkg::USED_BITS-1:0]      o_sensors_used,
    output logic                                o_degenerate_seen
);
    import rsef_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int TB    = TIME_BITS;
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);
    localparam int SUM_W = VB + CNT_W;

    t_state r_state, n_state;

    logic [MODE_BITS-1:0] r_mode;

    // latched request
    logic [VB-1:0] r_oldv, r_newv, r_lo, r_hi;
    logic [TB-1:0] r_oldt, r_newt, r_nowt;
    logic          r_last;

    // extrapolation datapath
    logic [VB:0]      r_dv;
    logic [TB:0]      r_dt, r_da;
    logic [VB-1:0]    r_dv_mag;
    logic [TB-1:0]    r_dt_mag, r_da_mag;
    logic             r_neg;
    logic             r_item_deg;
    logic [VAL_W-1:0] r_qs;
    logic [VAL_W-1:0] r_val;
    logic [VB-1:0]    r_cv;

    // round state
    logic [VB-1:0]    r_max, r_min;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic             r_degf;

    // output register
    logic                 r_out_valid;
    logic [VB-1:0]        r_fused;
    logic [USED_BITS-1:0] r_used;
    logic                 r_degen;

    // control
    logic in_acc, full, dt_zero, avg_go, div_start, emit_load;

    // shared divider
    logic [PROD_W-1:0] div_dividend, div_quot, prod;
    logic [TB-1:0]     div_divisor;
    t_div_stat         div_stat;

    // combinational helpers
    logic             dv_neg, dt_neg, da_neg;
    logic [VB:0]      dv_abs;
    logic [TB:0]      dt_abs, da_abs;
    logic [VAL_W-1:0] q_ext, lo_ext, hi_ext, c1, c2;
    logic [VB-1:0]    fused_sel;
    logic [CNT_W+USED_BITS-1:0] used_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign full        = (r_count >= CNT_W'(MAX_SENSORS));
    assign dt_zero     = (r_dt == '0);
    assign avg_go      = r_last && (r_mode == MODE_AVG) && (r_count != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_acc) n_state = full ? ST_CLOSE : ST_DIFF;
            ST_DIFF:     n_state = ST_MAG;
            ST_MAG:      n_state = dt_zero ? ST_FOLD : ST_MUL;
            ST_MUL:      n_state = ST_DIV_PROD;
            ST_DIV_PROD: if (div_stat.done) n_state = ST_SIGN;
            ST_SIGN:     n_state = ST_ADD;
            ST_ADD:      n_state = ST_FOLD;
            ST_FOLD:     n_state = ST_ACC;
            ST_ACC:      n_state = ST_CLOSE;
            ST_CLOSE: begin
                priority if (!r_last) n_state = ST_IDLE;
                else if (avg_go)      n_state = ST_DIV_AVG;
                else                  n_state = ST_EMIT;
            end
            ST_DIV_AVG:  if (div_stat.done) n_state = ST_EMIT;
            ST_EMIT:     if (emit_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        div_start = (r_state == ST_MUL) || ((r_state == ST_CLOSE) && avg_go);
        emit_load = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                       r_mode <= MODE_MAX;
        else if (i_cfg_valid && o_cfg_ready) r_mode <= i_cfg_data;
    end

    // Signed differences to magnitudes
    always_comb begin
        dv_neg = r_dv[VB];
        dt_neg = r_dt[TB];
        da_neg = r_da[TB];
        dv_abs = dv_neg ? (~r_dv + (VB+1)'(1)) : r_dv;
        dt_abs = dt_neg ? (~r_dt + (TB+1)'(1)) : r_dt;
        da_abs = da_neg ? (~r_da + (TB+1)'(1)) : r_da;
    end

    // Magnitude product, fed straight into the divider
    assign prod = r_dv_mag * r_da_mag;

    // Divider operands: extrapolation quotient or round average
    always_comb begin
        if (r_state == ST_CLOSE) begin
            div_dividend = PROD_W'(r_sum);
            div_divisor  = TB'(r_count);
        end else begin
            div_dividend = prod;
            div_divisor  = r_dt_mag;
        end
    end

    rsef_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (TB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quot),
        .o_stat     (div_stat)
    );

    // Clamp: raise to the low limit first, then cap at the high limit
    always_comb begin
        q_ext  = {2'b00, div_quot};
        lo_ext = {{(VAL_W-VB){1'b0}}, r_lo};
        hi_ext = {{(VAL_W-VB){1'b0}}, r_hi};
        c1     = ($signed(r_val) < $signed(lo_ext)) ? lo_ext : r_val;
        c2     = ($signed(c1) > $signed(hi_ext)) ? hi_ext : c1;
    end

    // Extrapolation datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_oldv     <= i_older_value;
                    r_newv     <= i_newer_value;
                    r_oldt     <= i_older_time;
                    r_newt     <= i_newer_time;
                    r_nowt     <= i_now_time;
                    r_lo       <= i_range_min;
                    r_hi       <= i_range_max;
                    r_last     <= i_last_sensor;
                    r_item_deg <= 1'b0;
                end
            end
            ST_DIFF: begin
                r_dv <= {1'b0, r_newv} - {1'b0, r_oldv};
                r_dt <= {1'b0, r_newt} - {1'b0, r_oldt};
                r_da <= {1'b0, r_nowt} - {1'b0, r_newt};
            end
            ST_MAG: begin
                r_dv_mag <= dv_abs[VB-1:0];
                r_dt_mag <= dt_abs[TB-1:0];
                r_da_mag <= da_abs[TB-1:0];
                r_neg    <= dv_neg ^ dt_neg ^ da_neg;
                // equal sample times: hold the newer reading
                if (dt_zero) begin
                    r_val      <= {{(VAL_W-VB){1'b0}}, r_newv};
                    r_item_deg <= 1'b1;
                end
            end
            ST_SIGN: r_qs  <= r_neg ? (~q_ext + VAL_W'(1)) : q_ext;
            ST_ADD:  r_val <= {{(VAL_W-VB){1'b0}}, r_newv} + r_qs;
            ST_FOLD: r_cv  <= c2[VB-1:0];
            default: ;
        endcase
    end

    // Round accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit_load) begin
            r_max   <= '0;
            r_min   <= '1;
            r_sum   <= '0;
            r_count <= '0;
            r_degf  <= 1'b0;
        end else if (r_state == ST_ACC) begin
            if (r_cv > r_max) r_max <= r_cv;
            if (r_cv < r_min) r_min <= r_cv;
            r_sum   <= r_sum + SUM_W'(r_cv);
            r_count <= r_count + CNT_W'(1);
            if (r_item_deg) r_degf <= 1'b1;
        end
    end

    // Fused value by mode
    always_comb begin
        unique case (r_mode)
            MODE_MIN: fused_sel = r_min;
            MODE_AVG: fused_sel = (r_count != '0) ? div_quot[VB-1:0] : '0;
            default:  fused_sel = r_max;
        endcase
        used_ext = {{USED_BITS{1'b0}}, r_count};
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_fused <= fused_sel;
            r_used  <= used_ext[USED_BITS-1:0];
            r_degen <= r_degf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_fused_value     = r_fused;
    assign o_sensors_used    = r_used;
    assign o_degenerate_seen = r_degen;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SENSORS))
        else $error("sensor count above round limit");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIV_PROD || r_state == ST_DIV_AVG))
        else $error("divider finished outside a wait state");

    a_round_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |=> (r_count == '0 && r_sum == '0 && !r_degf))
        else $error("round state not cleared after result");

endmodule

`default_nettype wire
